### hw/rtl/oss_pkg.sv
// ----------------------------------------------------------------------------
// oss_pkg
// types and constants shared by the online standard scaler
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = 32;
  localparam int MEAN_W    = 32;
  localparam int VAR_W     = 48;
  localparam int ENTRY_W   = CNT_W + MEAN_W + VAR_W;
  localparam int RES_W     = 66;
  localparam int STEP_W    = 7;

  localparam logic [1:0] ACT_LEARN     = 2'd0;
  localparam logic [1:0] ACT_TRANSFORM = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;

  localparam logic [STEP_W-1:0] DIV_STEPS_D  = 7'd33;
  localparam logic [STEP_W-1:0] DIV_STEPS_DV = 7'd48;
  localparam logic [STEP_W-1:0] DIV_STEPS_TR = 7'd49;
  localparam logic [STEP_W-1:0] MUL_STEPS    = 7'd33;
  localparam logic [STEP_W-1:0] SQRT_STEPS   = 7'd32;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_SCALE_EN = 1'b0;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [STEP_W-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         feature_index;
    logic signed [31:0] value;
    logic               last_of_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         feature_index_out;
    logic signed [31:0] scaled_value;
    logic               seen;
    logic               last_out;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_DISP,
    S_LDIV1,
    S_LMID,
    S_LMUL,
    S_LVAR,
    S_LDIV2,
    S_WRITE,
    S_TSQRT,
    S_TSTART,
    S_TDIV,
    S_OUT
  } state_t;

endpackage

### hw/rtl/online_standard_scaler.sv
// ----------------------------------------------------------------------------
// online_standard_scaler
// per-feature online mean and variance with standardization of values
// ----------------------------------------------------------------------------
// Input beats on in_valid/in_ready carry an action, a feature index, a Q16.16
// value and a last-of-sample flag. Learn beats update the feature's count and
// mean, and variance with scale_en set, and give no output. Transform beats
// give one output beat on out_valid/out_ready. Clear beats drop every
// feature's statistics at once. One beat is worked at a time: in_ready is high
// only while the sequencer is idle. After a learn beat in_ready stays low for
// divide 33 steps, multiply 33 steps, divide 48 steps, memory read and write,
// or divide and memory alone with scale_en clear. A transform puts out its
// result after root 32 steps and divide 49 steps, or neither when no root is
// needed; in_ready comes back in that same cycle. Clear and ignored beats
// leave in_ready high. All steps run through one shared divide/multiply/root
// unit. The result sits in an output register; the next input beat is accepted
// while it waits, and a later result waits until out_ready takes the first.
// Synchronous reset clears all seen bits and sets scale_en to 1; the stats
// memory needs no clearing. scale_en is written over the APB port at 0.
// ----------------------------------------------------------------------------
module online_standard_scaler #(
  parameter int NUM_FEATURES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  oss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output oss_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH = (NUM_FEATURES > 256) ? 256 : NUM_FEATURES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  oss_pkg::state_t state, state_next;

  logic scale_en;
  logic [DEPTH-1:0] seen_bits;
  logic [oss_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [oss_pkg::ENTRY_W-1:0] rd_data;

  logic [1:0]         act_q;
  logic [7:0]         idx_q;
  logic signed [31:0] x_q;
  logic               last_q;
  logic               ok_q;
  logic [AW-1:0]      addr_q;

  logic               seen_r;
  logic [31:0]        cnt_r;
  logic signed [31:0] m_r;
  logic [47:0]        v_r;
  logic signed [32:0] d_r;
  logic [49:0]        dv_r;
  logic [31:0]        sd_r;
  logic signed [31:0] res_r;

  oss_pkg::alu_req_t  req;
  logic [63:0]        alu_a;
  logic [32:0]        alu_b;
  logic               alu_done;
  logic [oss_pkg::RES_W-1:0] alu_res;

  logic in_acc;
  logic cfg_wr;
  logic ok_in;

  logic [32:0]        d_mag;
  logic signed [32:0] d2;
  logic [32:0]        d2_mag;
  logic signed [32:0] m_sum;
  logic [47:0]        p_sat;
  logic signed [49:0] v_sum;
  logic signed [32:0] d_load;
  logic signed [31:0] m_load;
  logic [31:0]        c_load;
  logic [47:0]        v_load;
  logic               seen_load;
  logic signed [31:0] d_sat;
  logic signed [31:0] q_sat;
  logic               q_big;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == oss_pkg::REG_SCALE_EN) ? {31'd0, scale_en} : 32'd0;
  assign in_acc = in_valid & in_ready;
  assign ok_in  = ({24'd0, in_data.feature_index} < NUM_FEATURES);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_en <= 1'b1;
    end else if (cfg_wr && paddr[2] == oss_pkg::REG_SCALE_EN) begin
      scale_en <= pwdata[0];
    end
  end

  oss_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (state == oss_pkg::S_WRITE) begin
      mem[addr_q] <= {cnt_r, m_r, v_r};
    end
    rd_data <= mem[addr_q];
  end

  // datapath helpers
  always_comb begin
    seen_load = ok_q & seen_bits[addr_q];
    c_load    = seen_load ? rd_data[oss_pkg::ENTRY_W-1 -: 32] : 32'd0;
    m_load    = seen_load ? rd_data[79:48] : 32'sd0;
    v_load    = seen_load ? rd_data[47:0] : 48'd0;
    d_load    = 33'(x_q) - 33'(m_load);
    d_mag     = d_r[32] ? 33'(-d_r) : 33'(d_r);
    m_sum     = 33'(m_r) + (d_r[32] ? 33'(-alu_res[32:0]) : 33'(alu_res[32:0]));
    d2        = 33'(x_q) - 33'(m_r);
    d2_mag    = d2[32] ? 33'(-d2) : 33'(d2);
    p_sat     = (alu_res[65:64] != 2'b00) ? 48'hFFFF_FFFF_FFFF : alu_res[63:16];
    v_sum     = 50'(v_r) + (dv_r[49] ? 50'(-alu_res[49:0]) : 50'(alu_res[49:0]));
    if (d_r > 33'sh0_7FFF_FFFF) begin
      d_sat = 32'sh7FFF_FFFF;
    end else if (d_r < -33'sh0_8000_0000) begin
      d_sat = -32'sh8000_0000;
    end else begin
      d_sat = d_r[31:0];
    end
    q_big = (alu_res[63:31] != 33'd0);
    if (d_r[32]) begin
      q_sat = q_big ? -32'sh8000_0000 : 32'(-alu_res[31:0]);
    end else begin
      q_sat = q_big ? 32'sh7FFF_FFFF : alu_res[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      oss_pkg::S_IDLE: begin
        if (in_acc && (in_data.action == oss_pkg::ACT_TRANSFORM ||
            (in_data.action == oss_pkg::ACT_LEARN && ok_in))) begin
          state_next = oss_pkg::S_READ;
        end
      end
      oss_pkg::S_READ: state_next = oss_pkg::S_LOAD;
      oss_pkg::S_LOAD: state_next = oss_pkg::S_DISP;
      oss_pkg::S_DISP: begin
        if (act_q == oss_pkg::ACT_LEARN) begin
          state_next = oss_pkg::S_LDIV1;
        end else if (scale_en && seen_r && v_r != 48'd0) begin
          state_next = oss_pkg::S_TSQRT;
        end else begin
          state_next = oss_pkg::S_OUT;
        end
      end
      oss_pkg::S_LDIV1: begin
        if (alu_done) begin
          state_next = scale_en ? oss_pkg::S_LMID : oss_pkg::S_WRITE;
        end
      end
      oss_pkg::S_LMID: state_next = oss_pkg::S_LMUL;
      oss_pkg::S_LMUL: begin
        if (alu_done) begin
          state_next = oss_pkg::S_LVAR;
        end
      end
      oss_pkg::S_LVAR: state_next = oss_pkg::S_LDIV2;
      oss_pkg::S_LDIV2: begin
        if (alu_done) begin
          state_next = oss_pkg::S_WRITE;
        end
      end
      oss_pkg::S_WRITE: state_next = oss_pkg::S_IDLE;
      oss_pkg::S_TSQRT: begin
        if (alu_done) begin
          state_next = oss_pkg::S_TSTART;
        end
      end
      oss_pkg::S_TSTART: state_next = oss_pkg::S_TDIV;
      oss_pkg::S_TDIV: begin
        if (alu_done) begin
          state_next = oss_pkg::S_OUT;
        end
      end
      oss_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = oss_pkg::S_IDLE;
        end
      end
      default: state_next = oss_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state == oss_pkg::S_IDLE);
    req.start = 1'b0;
    req.op    = oss_pkg::OP_DIV;
    req.steps = oss_pkg::DIV_STEPS_D;
    alu_a     = {d_mag, 31'd0};
    alu_b     = {1'b0, cnt_r};
    case (state)
      oss_pkg::S_DISP: begin
        if (act_q == oss_pkg::ACT_LEARN) begin
          req.start = 1'b1;
        end else if (scale_en && seen_r && v_r != 48'd0) begin
          req.start = 1'b1;
          req.op    = oss_pkg::OP_SQRT;
          req.steps = oss_pkg::SQRT_STEPS;
          alu_a     = {v_r, 16'd0};
        end
      end
      oss_pkg::S_LMID: begin
        req.start = 1'b1;
        req.op    = oss_pkg::OP_MUL;
        req.steps = oss_pkg::MUL_STEPS;
        alu_a     = {31'd0, d2_mag};
        alu_b     = d_mag;
      end
      oss_pkg::S_LVAR: begin
        req.start = 1'b1;
        req.steps = oss_pkg::DIV_STEPS_DV;
        alu_a     = {(dv_r[49] ? 48'(-dv_r) : dv_r[47:0]), 16'd0};
      end
      oss_pkg::S_TSTART: begin
        req.start = 1'b1;
        req.steps = oss_pkg::DIV_STEPS_TR;
        alu_b     = {1'b0, sd_r};
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oss_pkg::S_IDLE;
      seen_bits <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == oss_pkg::S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_acc && in_data.action == oss_pkg::ACT_CLEAR) begin
        seen_bits <= '0;
      end else if (state == oss_pkg::S_WRITE) begin
        seen_bits[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_q  <= in_data.action;
      idx_q  <= in_data.feature_index;
      x_q    <= in_data.value;
      last_q <= in_data.last_of_sample;
      ok_q   <= ok_in;
      addr_q <= in_data.feature_index[AW-1:0];
    end
    case (state)
      oss_pkg::S_LOAD: begin
        seen_r <= seen_load;
        cnt_r  <= (c_load == 32'hFFFF_FFFF) ? c_load : c_load + 32'd1;
        m_r    <= m_load;
        v_r    <= v_load;
        d_r    <= d_load;
      end
      oss_pkg::S_DISP: begin
        if (scale_en) begin
          res_r <= 32'sd0;
        end else begin
          res_r <= seen_r ? d_sat : x_q;
        end
      end
      oss_pkg::S_LDIV1: begin
        if (alu_done) begin
          m_r <= m_sum[31:0];
        end
      end
      oss_pkg::S_LMUL: begin
        if (alu_done) begin
          dv_r <= 50'({2'b00, p_sat}) - 50'({2'b00, v_r});
        end
      end
      oss_pkg::S_LDIV2: begin
        if (alu_done) begin
          v_r <= v_sum[47:0];
        end
      end
      oss_pkg::S_TSQRT: begin
        if (alu_done) begin
          sd_r <= alu_res[31:0];
        end
      end
      oss_pkg::S_TDIV: begin
        if (alu_done) begin
          res_r <= q_sat;
        end
      end
      oss_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          out_data.feature_index_out <= idx_q;
          out_data.scaled_value      <= res_r;
          out_data.seen              <= seen_r;
          out_data.last_out          <= last_q;
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

endmodule

### hw/rtl/oss_alu.sv
// ----------------------------------------------------------------------------
// oss_alu
// shared iterative unit: restoring divide, shift-add multiply, square root
// ----------------------------------------------------------------------------
module oss_alu (
  input  logic                    clk,
  input  logic                    rst,
  input  oss_pkg::alu_req_t       req,
  input  logic [63:0]             a,
  input  logic [32:0]             b,
  output logic                    done,
  output logic [oss_pkg::RES_W-1:0] res
);

  logic                          busy;
  oss_pkg::alu_op_t              op_r;
  logic [oss_pkg::STEP_W-1:0]    n;
  logic [65:0]                   acc;
  logic [63:0]                   q;
  logic [63:0]                   sh;
  logic [32:0]                   b_r;

  logic [65:0] acc_next;
  logic [63:0] q_next;
  logic [63:0] sh_next;
  logic [33:0] msum;
  logic [33:0] drem;
  logic [35:0] srem;
  logic [35:0] strial;

  always_comb begin
    msum     = {1'b0, acc[65:33]} + (sh[0] ? {1'b0, b_r} : 34'd0);
    drem     = {acc[32:0], sh[63]};
    srem     = {acc[33:0], sh[63:62]};
    strial   = {2'b00, q[31:0], 2'b01};
    acc_next = acc;
    q_next   = q;
    sh_next  = sh;
    case (op_r)
      oss_pkg::OP_MUL: begin
        acc_next = {msum, acc[32:1]};
        sh_next  = {1'b0, sh[63:1]};
      end
      oss_pkg::OP_DIV: begin
        if (drem >= {1'b0, b_r}) begin
          acc_next = {32'd0, drem - {1'b0, b_r}};
          q_next   = {q[62:0], 1'b1};
        end else begin
          acc_next = {32'd0, drem};
          q_next   = {q[62:0], 1'b0};
        end
        sh_next = {sh[62:0], 1'b0};
      end
      oss_pkg::OP_SQRT: begin
        if (srem >= strial) begin
          acc_next = {30'd0, srem - strial};
          q_next   = {q[62:0], 1'b1};
        end else begin
          acc_next = {30'd0, srem};
          q_next   = {q[62:0], 1'b0};
        end
        sh_next = {sh[61:0], 2'b00};
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      n    <= '0;
      op_r <= oss_pkg::OP_DIV;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      n    <= req.steps;
      op_r <= req.op;
    end else if (busy) begin
      n <= n - 1'b1;
      if (n == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      q   <= '0;
      sh  <= a;
      b_r <= b;
    end else if (busy) begin
      acc <= acc_next;
      q   <= q_next;
      sh  <= sh_next;
    end
  end

  always_comb begin
    if (op_r == oss_pkg::OP_MUL) begin
      res = acc;
    end else begin
      res = {2'b00, q};
    end
  end

endmodule
